FILE: sv/assert_macros.svh
// Assertion macros for the obb RTL.
// Expects a clock named clk and an active-high reset named rst in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, reset masked.
`define OBB_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, reset masked.
`define OBB_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

FILE: sv/obb_pkg.sv
// Shared types, constants and helpers for the oriented box overlap test.
// No dependencies.
package obb_pkg;

  localparam int FRAC_BITS     = 8;
  localparam int ANGLE_BITS    = 16;
  localparam int CORDIC_STEPS  = 24;
  localparam int SQRT_STEPS    = 23;
  localparam logic [31:0] CORDIC_GAIN = 32'd652032874;
  localparam logic [21:0] DEFAULT_SIZE_RST = 22'(60 << FRAC_BITS);

  localparam logic [31:0] ATAN_TAB [CORDIC_STEPS] = '{
    32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
    32'd21354465, 32'd10679838, 32'd5340245, 32'd2670163, 32'd1335087,
    32'd667544, 32'd333772, 32'd166886, 32'd83443, 32'd41722, 32'd20861,
    32'd10430, 32'd5215, 32'd2608, 32'd1304, 32'd652, 32'd326, 32'd163, 32'd81
  };

  // Widths: corner coords, differences, products, sums.
  localparam int PW  = 27;
  localparam int DW  = 28;
  localparam int PRW = 2 * DW;
  localparam int SW  = PRW + 1;

  // Front: 27 stage registers plus the corner register.
  localparam int NF          = 27;
  localparam int FRONT_DEPTH = NF + 1;
  localparam int TEST_DEPTH  = 5;
  localparam int PIPE_DEPTH  = FRONT_DEPTH + TEST_DEPTH;

  localparam logic [2:0] DEC_OUTER  = 3'd0;
  localparam logic [2:0] DEC_INNER  = 3'd1;
  localparam logic [2:0] DEC_CORNER = 3'd2;
  localparam logic [2:0] DEC_EDGE   = 3'd3;
  localparam logic [2:0] DEC_NONE   = 3'd4;

  localparam logic [1:0] ORI_ZERO = 2'd0;
  localparam logic [1:0] ORI_POS  = 2'd1;
  localparam logic [1:0] ORI_NEG  = 2'd2;

  typedef struct packed {
    logic signed [23:0] a_center_x;
    logic signed [23:0] a_center_y;
    logic [21:0]        a_width;
    logic [21:0]        a_height;
    logic [15:0]        a_angle;
    logic               a_rotate_enable;
    logic signed [23:0] b_center_x;
    logic signed [23:0] b_center_y;
    logic [21:0]        b_width;
    logic [21:0]        b_height;
    logic [15:0]        b_angle;
    logic               b_rotate_enable;
  } in_word_t;

  typedef struct packed {
    logic       overlap;
    logic [2:0] decided_by;
  } out_word_t;

  typedef struct packed {
    logic signed [23:0] center_x;
    logic signed [23:0] center_y;
    logic [21:0]        width;
    logic [21:0]        height;
    logic [15:0]        angle;
    logic               rotate_enable;
  } box_in_t;

  // Corners in Q.9, radii, centre in Q.9.
  typedef struct {
    logic signed [PW-1:0] px [4];
    logic signed [PW-1:0] py [4];
    logic [23:0]          outer;
    logic [21:0]          inner;
    logic signed [24:0]   cx;
    logic signed [24:0]   cy;
  } box_geom_t;

  function automatic logic signed [DW-1:0] pdiff(input logic signed [PW-1:0] a,
                                                 input logic signed [PW-1:0] b);
    return DW'(a) - DW'(b);
  endfunction

endpackage

FILE: sv/obb_box_front.sv
// Per-box front end: size defaulting, CORDIC sine/cosine, outer radius
// square root and corners, rotated when rotate_enable is set. Depends on obb_pkg.
module obb_box_front (
  input  logic            clk,
  input  logic            adv,
  input  logic [21:0]     default_box_size,
  input  obb_pkg::box_in_t box,
  output obb_pkg::box_geom_t geom
);
  import obb_pkg::*;

  localparam int CW = 33;
  localparam int MW = 46;

  typedef struct {
    logic [21:0]          w;
    logic [21:0]          h;
    logic signed [24:0]   cx;
    logic signed [24:0]   cy;
    logic                 rot;
    logic [1:0]           quad;
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic signed [CW-1:0] z;
    logic [43:0]          wsq;
    logic [43:0]          hsq;
    logic [MW-1:0]        m;
    logic [MW-1:0]        r;
    logic [23:0]          outer;
    logic [21:0]          inner;
    logic signed [CW-1:0] c;
    logic signed [CW-1:0] s;
    logic signed [55:0]   pa;
    logic signed [55:0]   pb;
    logic signed [55:0]   pd;
    logic signed [55:0]   pe;
  } fp_t;

  fp_t       st  [NF];
  fp_t       nxt [NF];
  box_geom_t geom_next;

  function automatic logic signed [PW-1:0] rnd30(input logic signed [56:0] v);
    logic signed [56:0] t;
    t = v + (57'sd1 <<< 29);
    return PW'(t >>> 30);
  endfunction

  // Stage 0: size defaulting, centre to Q.9, angle split.
  always_comb begin
    logic [31:0] ang32;
    ang32 = 32'(box.angle[ANGLE_BITS-1:0]) << (32 - ANGLE_BITS);
    nxt[0] = '{default: '0};
    if (box.width == '0 || box.height == '0) begin
      nxt[0].w = default_box_size;
      nxt[0].h = default_box_size;
    end else begin
      nxt[0].w = box.width;
      nxt[0].h = box.height;
    end
    nxt[0].cx   = $signed({box.center_x, 1'b0});
    nxt[0].cy   = $signed({box.center_y, 1'b0});
    nxt[0].rot  = box.rotate_enable;
    nxt[0].quad = ang32[31:30];
    nxt[0].x    = $signed(CW'(CORDIC_GAIN));
    nxt[0].y    = '0;
    nxt[0].z    = $signed(CW'(ang32[29:0]));
  end

  for (genvar k = 1; k < NF; k++) begin : g_st
    localparam int CI = (k - 1 < CORDIC_STEPS) ? k - 1 : 0;
    localparam int SB = (k >= 3 && k <= 25) ? 2 * (25 - k) : 0;
    always_comb begin
      logic signed [CW-1:0] xs;
      logic signed [CW-1:0] ys;
      logic [MW-1:0]        sbit;
      nxt[k] = st[k-1];
      xs   = st[k-1].x >>> CI;
      ys   = st[k-1].y >>> CI;
      sbit = MW'(1) << SB;
      if (k == 1) begin
        nxt[k].wsq = st[k-1].w * st[k-1].w;
        nxt[k].hsq = st[k-1].h * st[k-1].h;
      end
      if (k == 2) begin
        nxt[k].m = MW'(st[k-1].wsq) + MW'(st[k-1].hsq);
        nxt[k].r = '0;
      end
      // one restoring square root digit per stage
      if (k >= 3 && k <= 25) begin
        if (st[k-1].m >= st[k-1].r + sbit) begin
          nxt[k].m = st[k-1].m - (st[k-1].r + sbit);
          nxt[k].r = (st[k-1].r >> 1) + sbit;
        end else begin
          nxt[k].r = st[k-1].r >> 1;
        end
      end
      // one CORDIC rotation per stage
      if (k >= 1 && k <= CORDIC_STEPS) begin
        if (st[k-1].z >= 0) begin
          nxt[k].x = st[k-1].x - ys;
          nxt[k].y = st[k-1].y + xs;
          nxt[k].z = st[k-1].z - $signed(CW'(ATAN_TAB[CI]));
        end else begin
          nxt[k].x = st[k-1].x + ys;
          nxt[k].y = st[k-1].y - xs;
          nxt[k].z = st[k-1].z + $signed(CW'(ATAN_TAB[CI]));
        end
      end
      if (k == 25) begin
        case (st[k-1].quad)
          2'd0: begin nxt[k].c = st[k-1].x;  nxt[k].s = st[k-1].y;  end
          2'd1: begin nxt[k].c = -st[k-1].y; nxt[k].s = st[k-1].x;  end
          2'd2: begin nxt[k].c = -st[k-1].x; nxt[k].s = -st[k-1].y; end
          default: begin nxt[k].c = st[k-1].y; nxt[k].s = -st[k-1].x; end
        endcase
      end
      if (k == 26) begin
        // ceiling: bump when a remainder is left
        nxt[k].outer = 24'(st[k-1].r) + 24'(st[k-1].m != '0);
        nxt[k].inner = (st[k-1].w < st[k-1].h) ? st[k-1].w : st[k-1].h;
        nxt[k].pa = $signed({1'b0, st[k-1].w}) * st[k-1].c;
        nxt[k].pb = $signed({1'b0, st[k-1].h}) * st[k-1].s;
        nxt[k].pd = $signed({1'b0, st[k-1].w}) * st[k-1].s;
        nxt[k].pe = $signed({1'b0, st[k-1].h}) * st[k-1].c;
      end
    end
  end

  // Corner stage.
  always_comb begin
    logic signed [PW-1:0] cx;
    logic signed [PW-1:0] cy;
    logic signed [PW-1:0] w;
    logic signed [PW-1:0] h;
    logic signed [56:0]   a;
    logic signed [56:0]   b;
    logic signed [56:0]   d;
    logic signed [56:0]   e;
    cx = PW'(st[NF-1].cx);
    cy = PW'(st[NF-1].cy);
    w  = $signed(PW'(st[NF-1].w));
    h  = $signed(PW'(st[NF-1].h));
    a  = 57'(st[NF-1].pa);
    b  = 57'(st[NF-1].pb);
    d  = 57'(st[NF-1].pd);
    e  = 57'(st[NF-1].pe);
    geom_next.outer = st[NF-1].outer;
    geom_next.inner = st[NF-1].inner;
    geom_next.cx    = st[NF-1].cx;
    geom_next.cy    = st[NF-1].cy;
    if (st[NF-1].rot) begin
      geom_next.px[0] = cx + rnd30(-a + b); geom_next.py[0] = cy + rnd30(-d - e);
      geom_next.px[1] = cx + rnd30(a + b);  geom_next.py[1] = cy + rnd30(d - e);
      geom_next.px[2] = cx + rnd30(a - b);  geom_next.py[2] = cy + rnd30(d + e);
      geom_next.px[3] = cx + rnd30(-a - b); geom_next.py[3] = cy + rnd30(-d + e);
    end else begin
      geom_next.px[0] = cx - w; geom_next.py[0] = cy - h;
      geom_next.px[1] = cx + w; geom_next.py[1] = cy - h;
      geom_next.px[2] = cx + w; geom_next.py[2] = cy + h;
      geom_next.px[3] = cx - w; geom_next.py[3] = cy + h;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int k = 0; k < NF; k++) begin
        st[k] <= nxt[k];
      end
      geom <= geom_next;
    end
  end

endmodule

FILE: sv/oriented_box_overlap_test.sv
// Top level of the oriented box overlap test.
// Depends on obb_pkg, obb_box_front and assert_macros.svh.
//
// Takes one word per cycle holding two boxes while in_ready is high and returns
// one word per box pair: overlap and the test that decided it (outer circles
// apart, inner circles, corner inside, edges cross, no overlap). Throughput is
// one pair per cycle while in_ready is high.
// The depth is set by the 24-step CORDIC pipeline in each box front end,
// with the outer radius square root running alongside it, followed by
// five stages of differences, products, sums, compares and the decision.
// The whole pipeline advances together; an output register plus a skid
// register sit at the end, so input is taken while one result waits and
// in_ready drops only once both hold a word. default_box_size is to be written
// through cfg_wr_en/cfg_wr_data while the block is idle; the block does not enforce it.
`include "assert_macros.svh"

module oriented_box_overlap_test (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_wr_en,
  input  logic [21:0]        cfg_wr_data,
  input  logic               in_valid,
  output logic               in_ready,
  input  obb_pkg::in_word_t  in_word,
  output logic               out_valid,
  input  logic               out_ready,
  output obb_pkg::out_word_t out_word
);
  import obb_pkg::*;

  logic [21:0]     default_box_size;
  logic            adv;
  logic [PIPE_DEPTH-1:0] vld;
  box_in_t         box_in [2];
  box_geom_t       geo [2];

  // difference stage
  logic signed [DW-1:0] abx [2], aby [2], adx [2], ady [2];
  logic signed [DW-1:0] amx [2][4], amy [2][4], ex [2][4], ey [2][4];
  logic signed [DW-1:0] rqx [2][4][4], rqy [2][4][4];
  logic signed [DW-1:0] dx, dy, ro, ri;
  // product stage
  logic signed [PRW-1:0] p_amab0 [2][4], p_amab1 [2][4];
  logic signed [PRW-1:0] p_amad0 [2][4], p_amad1 [2][4];
  logic signed [PRW-1:0] p_abab0 [2], p_abab1 [2], p_adad0 [2], p_adad1 [2];
  logic signed [PRW-1:0] p_or0 [2][4][4], p_or1 [2][4][4];
  logic signed [PRW-1:0] p_dx, p_dy, p_ro, p_ri;
  // sum stage
  logic signed [SW-1:0] amab [2][4], amad [2][4], abab [2], adad [2];
  logic signed [SW-1:0] ov [2][4][4];
  logic signed [SW-1:0] d2, ro2, ri2;
  // compare stage
  logic       ins [2][4];
  logic [1:0] oc [2][4][4];
  logic       far, near;
  // decision stage and output side
  out_word_t  dec_next, p_word, skid_word;
  logic       skid_v;

  assign adv      = !skid_v;
  assign in_ready = adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      default_box_size <= DEFAULT_SIZE_RST;
    end else if (cfg_wr_en) begin
      default_box_size <= cfg_wr_data;
    end
  end

  assign box_in[0] = '{in_word.a_center_x, in_word.a_center_y, in_word.a_width,
                       in_word.a_height, in_word.a_angle, in_word.a_rotate_enable};
  assign box_in[1] = '{in_word.b_center_x, in_word.b_center_y, in_word.b_width,
                       in_word.b_height, in_word.b_angle, in_word.b_rotate_enable};

  for (genvar g = 0; g < 2; g++) begin : g_front
    obb_box_front u_front (
      .clk              (clk),
      .adv              (adv),
      .default_box_size (default_box_size),
      .box              (box_in[g]),
      .geom             (geo[g])
    );
  end

  // Valid bits ride alongside the data; everything moves on adv.
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[PIPE_DEPTH-2:0], in_valid};
    end
  end

  // Box x tests the corners of box 1-x; orientation tables are edge of x
  // against corners of the other box.
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int x = 0; x < 2; x++) begin
        abx[x] <= pdiff(geo[x].px[1], geo[x].px[0]);
        aby[x] <= pdiff(geo[x].py[1], geo[x].py[0]);
        adx[x] <= pdiff(geo[x].px[3], geo[x].px[0]);
        ady[x] <= pdiff(geo[x].py[3], geo[x].py[0]);
        for (int i = 0; i < 4; i++) begin
          amx[x][i] <= pdiff(geo[1-x].px[i], geo[x].px[0]);
          amy[x][i] <= pdiff(geo[1-x].py[i], geo[x].py[0]);
          ex[x][i]  <= pdiff(geo[x].px[(i+1) & 3], geo[x].px[i]);
          ey[x][i]  <= pdiff(geo[x].py[(i+1) & 3], geo[x].py[i]);
          for (int j = 0; j < 4; j++) begin
            rqx[x][i][j] <= pdiff(geo[1-x].px[j], geo[x].px[(i+1) & 3]);
            rqy[x][i][j] <= pdiff(geo[1-x].py[j], geo[x].py[(i+1) & 3]);
          end
        end
      end
      dx <= DW'(geo[1].cx) - DW'(geo[0].cx);
      dy <= DW'(geo[1].cy) - DW'(geo[0].cy);
      ro <= $signed(DW'(geo[0].outer) + DW'(geo[1].outer));
      ri <= $signed(DW'(geo[0].inner) + DW'(geo[1].inner));
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int x = 0; x < 2; x++) begin
        p_abab0[x] <= abx[x] * abx[x];
        p_abab1[x] <= aby[x] * aby[x];
        p_adad0[x] <= adx[x] * adx[x];
        p_adad1[x] <= ady[x] * ady[x];
        for (int i = 0; i < 4; i++) begin
          p_amab0[x][i] <= amx[x][i] * abx[x];
          p_amab1[x][i] <= amy[x][i] * aby[x];
          p_amad0[x][i] <= amx[x][i] * adx[x];
          p_amad1[x][i] <= amy[x][i] * ady[x];
          for (int j = 0; j < 4; j++) begin
            p_or0[x][i][j] <= ey[x][i] * rqx[x][i][j];
            p_or1[x][i][j] <= ex[x][i] * rqy[x][i][j];
          end
        end
      end
      p_dx <= dx * dx;
      p_dy <= dy * dy;
      p_ro <= ro * ro;
      p_ri <= ri * ri;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int x = 0; x < 2; x++) begin
        abab[x] <= SW'(p_abab0[x]) + SW'(p_abab1[x]);
        adad[x] <= SW'(p_adad0[x]) + SW'(p_adad1[x]);
        for (int i = 0; i < 4; i++) begin
          amab[x][i] <= SW'(p_amab0[x][i]) + SW'(p_amab1[x][i]);
          amad[x][i] <= SW'(p_amad0[x][i]) + SW'(p_amad1[x][i]);
          for (int j = 0; j < 4; j++) begin
            ov[x][i][j] <= SW'(p_or0[x][i][j]) - SW'(p_or1[x][i][j]);
          end
        end
      end
      d2  <= SW'(p_dx) + SW'(p_dy);
      ro2 <= SW'(p_ro);
      ri2 <= SW'(p_ri);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int x = 0; x < 2; x++) begin
        for (int i = 0; i < 4; i++) begin
          // strict inside on both axes
          ins[x][i] <= (amab[x][i] > 0) && (amab[x][i] < abab[x]) &&
                       (amad[x][i] > 0) && (amad[x][i] < adad[x]);
          for (int j = 0; j < 4; j++) begin
            if (ov[x][i][j] == 0) begin
              oc[x][i][j] <= ORI_ZERO;
            end else if (ov[x][i][j] > 0) begin
              oc[x][i][j] <= ORI_POS;
            end else begin
              oc[x][i][j] <= ORI_NEG;
            end
          end
        end
      end
      far  <= d2 > ro2;
      near <= d2 < ri2;
    end
  end

  // Decision in test order.
  always_comb begin
    logic any_ins;
    logic any_cross;
    any_ins   = 1'b0;
    any_cross = 1'b0;
    for (int i = 0; i < 4; i++) begin
      any_ins = any_ins | ins[0][i] | ins[1][i];
      for (int j = 0; j < 4; j++) begin
        if (oc[0][i][j] != oc[0][i][(j+1) & 3] &&
            oc[1][j][i] != oc[1][j][(i+1) & 3]) begin
          any_cross = 1'b1;
        end
      end
    end
    if (far) begin
      dec_next = '{1'b0, DEC_OUTER};
    end else if (near) begin
      dec_next = '{1'b1, DEC_INNER};
    end else if (any_ins) begin
      dec_next = '{1'b1, DEC_CORNER};
    end else if (any_cross) begin
      dec_next = '{1'b1, DEC_EDGE};
    end else begin
      dec_next = '{1'b0, DEC_NONE};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      p_word <= dec_next;
    end
  end

  // Output register with skid: the skid fills only when the output
  // register is stalled and the pipeline delivers a word.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      skid_v    <= 1'b0;
    end else if (!out_valid || out_ready) begin
      if (skid_v) begin
        out_valid <= 1'b1;
        skid_v    <= 1'b0;
      end else begin
        out_valid <= vld[PIPE_DEPTH-1];
      end
    end else if (adv && vld[PIPE_DEPTH-1]) begin
      skid_v <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid || out_ready) begin
      out_word <= skid_v ? skid_word : p_word;
    end
    if (out_valid && !out_ready && adv) begin
      skid_word <= p_word;
    end
  end

  `OBB_ASSERT_NOW(a_skid_needs_out, skid_v, out_valid, "skid holds a word with output empty")
  `OBB_ASSERT_NXT(a_skid_drains, skid_v && out_ready, out_valid && !skid_v, "skid did not drain")
  `OBB_ASSERT_NOW(a_code_range, out_valid, out_word.decided_by <= DEC_NONE, "bad decision code")
  `OBB_ASSERT_NOW(a_overlap_code, out_valid, out_word.overlap == (out_word.decided_by == DEC_INNER || out_word.decided_by == DEC_CORNER || out_word.decided_by == DEC_EDGE), "overlap flag disagrees with code")

endmodule
